### hdl/eprd_pkg.sv
`default_nettype none

package eprd_pkg;

   // Reciprocals for division by constants. floor(x / 15) equals
   // (x * RECIP_15) >> RECIP_15_SHIFT for every 32-bit x, and likewise for 3.
   localparam logic [31:0] RECIP_15       = 32'h8888_8889;
   localparam int          RECIP_15_SHIFT = 35;
   localparam logic [31:0] RECIP_3        = 32'hAAAA_AAAB;
   localparam int          RECIP_3_SHIFT  = 33;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_NIGHT_START  = 2'd0;
   localparam logic [1:0] CSR_NIGHT_END    = 2'd1;
   localparam logic [1:0] CSR_TEMP_BAND    = 2'd2;
   localparam logic [1:0] CSR_BATTERY_BAND = 2'd3;

   localparam logic [4:0]  NIGHT_START_RST  = 5'd0;
   localparam logic [4:0]  NIGHT_END_RST    = 5'd6;
   localparam logic [7:0]  TEMP_BAND_RST    = 8'd3;
   localparam logic [15:0] BATTERY_BAND_RST = 16'd100;

   // Codes that mean "nothing seen yet" in the tracking registers.
   localparam logic [6:0]  MINUTE_NONE     = 7'd100;
   localparam logic [6:0]  HOUR_NONE       = 7'd100;
   localparam logic [1:0]  LINK_NONE       = 2'd3;
   localparam logic [15:0] FROZEN_BATT_RST = 16'hFFFF;

   localparam logic [6:0] HOUR_CAP  = 7'd99;
   localparam logic [3:0] CAUSE_CAP = 4'd9;

   typedef struct packed {
      logic [31:0]       time_seconds;
      logic              time_was_set;
      logic              link_connected;
      logic signed [7:0] panel_temperature;
      logic [15:0]       battery_millivolts;
   } req_payload_type;

   typedef struct packed {
      logic              paint;
      logic              full_refresh;
      logic [15:0]       shown_battery;
      logic signed [7:0] shown_temperature;
      logic [6:0]        hour_cause_count;
      logic [3:0]        temp_cause_count;
      logic [3:0]        battery_cause_count;
      logic [3:0]        link_cause_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [4:0]  quiet_from_hour;
      logic [4:0]  quiet_until_hour;
      logic [7:0]  temp_dead_band;
      logic [15:0] battery_dead_band;
   } cfg_type;

   // Request fields that ride along the time pipeline unchanged.
   typedef struct packed {
      logic        time_was_set;
      logic        link_connected;
      logic [7:0]  panel_temperature;
      logic [15:0] battery_millivolts;
   } side_type;

   typedef struct packed {
      logic [5:0] minute;
      logic [4:0] hour;
      side_type   side;
   } time_item_type;

endpackage

`default_nettype wire

### hdl/eprd_chan_if.sv
`default_nettype none

interface eprd_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hdl/eprd_time_split.sv
`default_nettype none

// Four-stage pipeline that turns the seconds clock into minute of hour and
// hour of day using reciprocal multiplications, one feeding each of stages 1 to 3.
module eprd_time_split (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire eprd_pkg::req_payload_type in_payload,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output eprd_pkg::time_item_type       out_item
);

   // Stage 0: request register.
   logic                      s0_valid_ff;
   eprd_pkg::req_payload_type s0_ff;
   // Stage 1: q1 = t / 60.
   logic                      s1_valid_ff;
   logic [26:0]               s1_q1_ff;
   eprd_pkg::side_type        s1_side_ff;
   // Stage 2: q2 = q1 / 60.
   logic                      s2_valid_ff;
   logic [5:0]                s2_q1_lo_ff;
   logic [20:0]               s2_q2_ff;
   eprd_pkg::side_type        s2_side_ff;
   // Stage 3: minute, plus low bits of q2 and q3 = q2 / 24.
   logic                      s3_valid_ff;
   logic [5:0]                s3_minute_ff;
   logic [4:0]                s3_q2_lo_ff;
   logic [1:0]                s3_q3_lo_ff;
   eprd_pkg::side_type        s3_side_ff;

   logic        s0_ready, s1_ready, s2_ready, s3_ready;
   logic [61:0] prod1;
   logic [55:0] prod2;
   logic [34:0] prod3;
   logic [5:0]  minute_in;
   eprd_pkg::side_type s0_side;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign s0_ready = !s0_valid_ff || s1_ready;
   assign in_ready = s0_ready;

   assign s0_side.time_was_set       = s0_ff.time_was_set;
   assign s0_side.link_connected     = s0_ff.link_connected;
   assign s0_side.panel_temperature  = s0_ff.panel_temperature;
   assign s0_side.battery_millivolts = s0_ff.battery_millivolts;

   // t / 60 = (t >> 2) / 15; q1 / 60 = (q1 >> 2) / 15; q2 / 24 = (q2 >> 3) / 3.
   assign prod1 = 62'(s0_ff.time_seconds[31:2]) * 62'(eprd_pkg::RECIP_15);
   assign prod2 = 56'(s1_q1_ff[26:2]) * 56'(eprd_pkg::RECIP_15);
   assign prod3 = 35'(s2_q2_ff[20:3]) * 35'(eprd_pkg::RECIP_3);

   // q1 - 60 * q2 = q1 - 64 * q2 + 4 * q2, so modulo 64 only low bits matter.
   assign minute_in = s2_q1_lo_ff + {s2_q2_ff[3:0], 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s0_ready) begin
            s0_valid_ff <= in_valid;
         end
         if (s1_ready) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && in_valid) begin
         s0_ff <= in_payload;
      end
      if (s1_ready && s0_valid_ff) begin
         s1_q1_ff   <= prod1[61:35];
         s1_side_ff <= s0_side;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_q1_lo_ff <= s1_q1_ff[5:0];
         s2_q2_ff    <= prod2[55:35];
         s2_side_ff  <= s1_side_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_minute_ff <= minute_in;
         s3_q2_lo_ff  <= s2_q2_ff[4:0];
         s3_q3_lo_ff  <= prod3[34:33];
         s3_side_ff   <= s2_side_ff;
      end
   end

   // hour = q2 - 24 * q3 = q2 - 16 * q3 - 8 * q3, taken modulo 32.
   assign out_valid     = s3_valid_ff;
   assign out_item.minute = s3_minute_ff;
   assign out_item.hour = s3_q2_lo_ff - {s3_q3_lo_ff[0], 4'b0000}
                          - {s3_q3_lo_ff[1:0], 3'b000};
   assign out_item.side = s3_side_ff;

endmodule

`default_nettype wire

### hdl/eprd_decide.sv
`default_nettype none

// Refresh decision against the tracked state, with the result register.
module eprd_decide (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire eprd_pkg::cfg_type       cfg,
   input  wire logic                    item_valid,
   output logic                         item_ready,
   input  wire eprd_pkg::time_item_type item,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output eprd_pkg::rsp_payload_type    rsp_payload
);

   logic [6:0]  last_minute_ff, last_minute_in;
   logic [6:0]  last_hour_ff, last_hour_in;
   logic [1:0]  last_link_ff, last_link_in;
   logic        temp_valid_ff, temp_valid_in;
   logic [7:0]  last_temp_ff, last_temp_in;
   logic        battery_valid_ff, battery_valid_in;
   logic [15:0] last_battery_ff, last_battery_in;
   logic        first_paint_done_ff, first_paint_done_in;
   logic        counters_armed_ff, counters_armed_in;
   logic [6:0]  count_hour_ff, count_hour_in;
   logic [3:0]  count_temp_ff, count_temp_in;
   logic [3:0]  count_battery_ff, count_battery_in;
   logic [3:0]  count_link_ff, count_link_in;
   logic [15:0] frozen_battery_ff, frozen_battery_in;
   logic [7:0]  frozen_temp_ff, frozen_temp_in;
   logic        rsp_valid_ff;
   eprd_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic        load, tick, forced;
   logic        c_link, c_temp, c_batt, hour_moved, full_c, night, paint_c, bump;
   logic [7:0]  temp_cur;
   logic [15:0] batt_now;
   logic [8:0]  temp_diff, temp_abs9;
   logic [7:0]  temp_abs;
   logic [15:0] batt_abs;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign load       = item_valid && item_ready;

   assign forced   = item.side.time_was_set;
   assign temp_cur = item.side.panel_temperature;
   assign batt_now = item.side.battery_millivolts;
   assign tick     = forced || ({1'b0, item.minute} != last_minute_ff);

   assign c_link = {1'b0, item.side.link_connected} != last_link_ff;

   assign temp_diff = {temp_cur[7], temp_cur} - {last_temp_ff[7], last_temp_ff};
   assign temp_abs9 = temp_diff[8] ? (9'd0 - temp_diff) : temp_diff;
   assign temp_abs  = temp_abs9[7:0];
   assign c_temp    = !temp_valid_ff || (temp_abs >= cfg.temp_dead_band);

   assign batt_abs = (batt_now > last_battery_ff) ? (batt_now - last_battery_ff)
                                                   : (last_battery_ff - batt_now);
   assign c_batt   = battery_valid_ff && (batt_abs >= cfg.battery_dead_band);

   assign hour_moved = {2'b00, item.hour} != last_hour_ff;
   assign full_c     = hour_moved || c_link || c_temp || c_batt;
   assign night      = (item.hour >= cfg.quiet_from_hour)
                       && (item.hour < cfg.quiet_until_hour);
   assign paint_c    = forced || !first_paint_done_ff || !night;
   assign bump       = paint_c && full_c && counters_armed_ff;

   always_comb begin
      last_minute_in      = last_minute_ff;
      last_hour_in        = last_hour_ff;
      last_link_in        = last_link_ff;
      temp_valid_in       = temp_valid_ff;
      last_temp_in        = last_temp_ff;
      battery_valid_in    = battery_valid_ff;
      last_battery_in     = last_battery_ff;
      first_paint_done_in = first_paint_done_ff;
      counters_armed_in   = counters_armed_ff;
      count_hour_in       = count_hour_ff;
      count_temp_in       = count_temp_ff;
      count_battery_in    = count_battery_ff;
      count_link_in       = count_link_ff;
      frozen_battery_in   = frozen_battery_ff;
      frozen_temp_in      = frozen_temp_ff;
      if (load && tick) begin
         last_minute_in    = {1'b0, item.minute};
         last_hour_in      = {2'b00, item.hour};
         last_link_in      = {1'b0, item.side.link_connected};
         temp_valid_in     = 1'b1;
         battery_valid_in  = 1'b1;
         counters_armed_in = 1'b1;
         if (c_temp) begin
            last_temp_in = temp_cur;
         end
         if (!battery_valid_ff || c_batt) begin
            last_battery_in = batt_now;
         end
         if (bump) begin
            if (c_link && (count_link_ff < eprd_pkg::CAUSE_CAP)) begin
               count_link_in = count_link_ff + 4'd1;
            end
            if (c_temp && (count_temp_ff < eprd_pkg::CAUSE_CAP)) begin
               count_temp_in = count_temp_ff + 4'd1;
            end
            if (c_batt && (count_battery_ff < eprd_pkg::CAUSE_CAP)) begin
               count_battery_in = count_battery_ff + 4'd1;
            end
            if (hour_moved && (count_hour_ff < eprd_pkg::HOUR_CAP)) begin
               count_hour_in = count_hour_ff + 7'd1;
            end
         end
         if (paint_c) begin
            first_paint_done_in = 1'b1;
            if (full_c) begin
               frozen_battery_in = batt_now;
               frozen_temp_in    = temp_cur;
            end
         end
      end
   end

   always_comb begin
      rsp_in.paint               = tick && paint_c;
      rsp_in.full_refresh        = tick && paint_c && full_c;
      rsp_in.shown_battery       = frozen_battery_in;
      rsp_in.shown_temperature   = frozen_temp_in;
      rsp_in.hour_cause_count    = count_hour_in;
      rsp_in.temp_cause_count    = count_temp_in;
      rsp_in.battery_cause_count = count_battery_in;
      rsp_in.link_cause_count    = count_link_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_minute_ff      <= eprd_pkg::MINUTE_NONE;
         last_hour_ff        <= eprd_pkg::HOUR_NONE;
         last_link_ff        <= eprd_pkg::LINK_NONE;
         temp_valid_ff       <= 1'b0;
         last_temp_ff        <= 8'd0;
         battery_valid_ff    <= 1'b0;
         last_battery_ff     <= 16'd0;
         first_paint_done_ff <= 1'b0;
         counters_armed_ff   <= 1'b0;
         count_hour_ff       <= 7'd0;
         count_temp_ff       <= 4'd0;
         count_battery_ff    <= 4'd0;
         count_link_ff       <= 4'd0;
         frozen_battery_ff   <= eprd_pkg::FROZEN_BATT_RST;
         frozen_temp_ff      <= 8'd0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         last_minute_ff      <= last_minute_in;
         last_hour_ff        <= last_hour_in;
         last_link_ff        <= last_link_in;
         temp_valid_ff       <= temp_valid_in;
         last_temp_ff        <= last_temp_in;
         battery_valid_ff    <= battery_valid_in;
         last_battery_ff     <= last_battery_in;
         first_paint_done_ff <= first_paint_done_in;
         counters_armed_ff   <= counters_armed_in;
         count_hour_ff       <= count_hour_in;
         count_temp_ff       <= count_temp_in;
         count_battery_ff    <= count_battery_in;
         count_link_ff       <= count_link_in;
         frozen_battery_ff   <= frozen_battery_in;
         frozen_temp_ff      <= frozen_temp_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_counter_caps: assert property (@(posedge clock) disable iff (reset)
      (count_hour_ff <= eprd_pkg::HOUR_CAP) && (count_temp_ff <= eprd_pkg::CAUSE_CAP)
      && (count_battery_ff <= eprd_pkg::CAUSE_CAP) && (count_link_ff <= eprd_pkg::CAUSE_CAP))
      else $error("cause counter above its cap");

   a_armed_sticks: assert property (@(posedge clock) disable iff (reset)
      counters_armed_ff |=> counters_armed_ff)
      else $error("counters disarmed without reset");

   a_full_freezes: assert property (@(posedge clock) disable iff (reset)
      (load && rsp_in.full_refresh) |=>
         (rsp_ff.shown_battery == $past(batt_now)) && rsp_ff.paint)
      else $error("full refresh did not freeze the battery value");

   a_counts_move_on_full: assert property (@(posedge clock) disable iff (reset)
      !(load && rsp_in.full_refresh) |=>
         $stable(count_hour_ff) && $stable(count_temp_ff)
         && $stable(count_battery_ff) && $stable(count_link_ff))
      else $error("cause counter moved without a painted full refresh");

endmodule

`default_nettype wire

### hdl/epaper_refresh_decider_core.sv
`default_nettype none

// Channel   Direction  Payload                     Handshake
// req_chan  in         req_payload_type (58 bits)  valid/ready
// rsp_chan  out        rsp_payload_type (45 bits)  valid/ready
// csr_*     in         2-bit index, 16-bit data    write enable only
//
// One request is taken per cycle while no stage is stalled; its result passes
// through the request register, the three reciprocal multiplier stages that
// split the seconds clock into minute and hour, and the decision stage register.
// Reset is synchronous and active high; no memory clearing pass is needed.
// Every stage loads when it is empty or its successor moves, so a stalled
// result holds in its register while earlier stages keep filling.

module epaper_refresh_decider_core (
   input  wire logic    clock,
   input  wire logic    reset,
   eprd_chan_if.sink    req_chan,
   eprd_chan_if.source  rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   eprd_pkg::cfg_type       cfg_ff, cfg_in;
   logic                    time_valid;
   logic                    time_ready;
   eprd_pkg::time_item_type time_item;
   logic                    split_ready;
   logic                    rsp_valid;
   eprd_pkg::rsp_payload_type rsp_payload;

   // Configuration registers. The user must write them only while the block is idle;
   // the block itself does not enforce it, and the decision stage reads them unshadowed.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            eprd_pkg::CSR_NIGHT_START: begin
               cfg_in.quiet_from_hour = csr_wdata[4:0];
            end
            eprd_pkg::CSR_NIGHT_END: begin
               cfg_in.quiet_until_hour = csr_wdata[4:0];
            end
            eprd_pkg::CSR_TEMP_BAND: begin
               cfg_in.temp_dead_band = csr_wdata[7:0];
            end
            eprd_pkg::CSR_BATTERY_BAND: begin
               cfg_in.battery_dead_band = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quiet_from_hour   <= eprd_pkg::NIGHT_START_RST;
         cfg_ff.quiet_until_hour  <= eprd_pkg::NIGHT_END_RST;
         cfg_ff.temp_dead_band    <= eprd_pkg::TEMP_BAND_RST;
         cfg_ff.battery_dead_band <= eprd_pkg::BATTERY_BAND_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: the request register and the minute and hour split.
   eprd_time_split u_time_split (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (split_ready),
      .in_payload (req_chan.payload),
      .out_valid  (time_valid),
      .out_ready  (time_ready),
      .out_item   (time_item)
   );

   assign req_chan.ready = split_ready;

   // Back end: the tracked state, the refresh decision and the result register.
   eprd_decide u_decide (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .item_valid  (time_valid),
      .item_ready  (time_ready),
      .item        (time_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_payload)
   );

   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;

endmodule

`default_nettype wire
